// ===== sv/pwl_pkg.sv =====
// Shared types, codes and sizes for the piecewise linear curve evaluator.
package pwl_pkg;

    // Table size and derived widths
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int COUNT_W    = 7;
    localparam int INDEX_W    = 6;
    localparam int VAL_W      = 32;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 32;
    localparam int STATUS_W   = 2;

    // Divider size: dividend bits, one per iteration
    localparam int DIV_N      = 2 * VAL_W;
    localparam int DIV_CNT_W  = $clog2(DIV_N + 1);

    localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

    // Request kinds
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INTERP = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOW    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HIGH   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Read address operations
    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_INC
    } addr_op_t;

    // Result register operations
    typedef enum logic [2:0] {
        RES_HOLD,
        RES_ONE,
        RES_RD_LOW,
        RES_RD_HIGH,
        RES_Y0_MID,
        RES_QUOT
    } res_op_t;

    // Arithmetic operations
    typedef enum logic [2:0] {
        CALC_NONE,
        CALC_DIFF,
        CALC_MUL,
        CALC_ROUND,
        CALC_DIV_START
    } calc_op_t;

    // Datapath controls from one control word
    typedef struct packed {
        logic     in_ready;
        addr_op_t addr_op;
        logic     pair_shift;
        logic     flag_sample;
        res_op_t  res_op;
        calc_op_t calc_op;
        logic     emit;
    } dp_ctrl_t;

    // Datapath flags tested by jumps
    typedef struct packed {
        logic eval_accept;
        logic empty;
        logic le_first;
        logic ge_last;
        logic scan_on;
        logic not_found;
        logic zero_width;
        logic div_busy;
        logic out_full;
    } dp_flags_t;

endpackage

// ===== sv/pwl_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
module pwl_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [2*pwl_pkg::VAL_W-1:0] dividend,
    input  logic [pwl_pkg::VAL_W-1:0] divisor,
    output logic                      busy,
    output logic [pwl_pkg::VAL_W-1:0] quotient
);
    import pwl_pkg::*;

    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_CNT_W-1:0] count_next;
    logic [DIV_N-1:0]     quo_reg;
    logic [DIV_N-1:0]     quo_next;
    logic [VAL_W-1:0]     rem_reg;
    logic [VAL_W-1:0]     rem_next;
    logic [VAL_W:0]       shifted;
    logic [VAL_W:0]       diff;

    // Trial subtract of the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[DIV_N-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            count_next = DIV_CNT_W'(DIV_N);
            quo_next   = dividend;
            rem_next   = '0;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            if (!diff[VAL_W])
            begin
                rem_next = diff[VAL_W-1:0];
                quo_next = {quo_reg[DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VAL_W-1:0];
                quo_next = {quo_reg[DIV_N-2:0], 1'b0};
            end
        end
    end

    // Hold iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Advance remainder and quotient
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = quo_reg[VAL_W-1:0];

endmodule

// ===== sv/pwl_datapath.sv =====
// Breakpoint memories, compare, multiply, result and output registers.
module pwl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pwl_pkg::dp_ctrl_t             ctrl,
    output pwl_pkg::dp_flags_t            flags,
    input  logic                          cfg_wr_en,
    input  logic [pwl_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_command,
    input  logic [pwl_pkg::INDEX_W-1:0]   in_point_index,
    input  logic [pwl_pkg::VAL_W-1:0]     in_point_x,
    input  logic [pwl_pkg::VAL_W-1:0]     in_point_y,
    input  logic [pwl_pkg::VAL_W-1:0]     in_time_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pwl_pkg::VAL_W-1:0]     out_curve_value,
    output logic [pwl_pkg::STATUS_W-1:0]  out_eval_status
);
    import pwl_pkg::*;

    logic [VAL_W-1:0]    mem_x [MAX_POINTS];
    logic [VAL_W-1:0]    mem_y [MAX_POINTS];

    logic [COUNT_W-1:0]  point_count_reg;
    logic [CNT_W-1:0]    num_points;
    logic [CNT_W-1:0]    addr_reg;
    logic [CNT_W-1:0]    addr_next;
    logic [CNT_W-1:0]    rd_addr_reg;
    logic [VAL_W-1:0]    rdx_reg;
    logic [VAL_W-1:0]    rdy_reg;
    logic [VAL_W-1:0]    t_reg;
    logic [VAL_W-1:0]    ax_reg;
    logic [VAL_W-1:0]    ay_reg;
    logic [VAL_W-1:0]    bx_reg;
    logic [VAL_W-1:0]    by_reg;
    logic                found_reg;
    logic [VAL_W-1:0]    dx_reg;
    logic [VAL_W-1:0]    dt_reg;
    logic [VAL_W-1:0]    mag_reg;
    logic                neg_reg;
    logic [2*VAL_W-1:0]  prod_reg;
    logic [2*VAL_W-1:0]  numer_reg;
    logic [VAL_W-1:0]    result_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                out_valid_reg;
    logic [VAL_W-1:0]    out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                accept;
    logic                load_wr;
    logic                scan_end;
    logic                scan_hit;
    logic [VAL_W:0]      dy;
    logic [VAL_W:0]      dy_abs;
    logic [2*VAL_W-1:0]  prod_c;
    logic                div_busy;
    logic [VAL_W-1:0]    quotient;
    logic                out_load;

    assign accept  = in_valid && ctrl.in_ready;
    assign load_wr = accept && (in_command == CMD_LOAD)
                     && (32'(in_point_index) < 32'(MAX_POINTS));

    // Clip the programmed count to the table size
    assign num_points = (32'(point_count_reg) > 32'(MAX_POINTS))
                        ? CNT_W'(MAX_POINTS) : CNT_W'(point_count_reg);

    // Scan compares: current pair (a, read data)
    assign scan_end = (rd_addr_reg >= num_points);
    assign scan_hit = ($signed(t_reg) >= $signed(ax_reg))
                      && ($signed(t_reg) <= $signed(rdx_reg));

    // Signed span of the ordinates
    assign dy     = {ay_reg[VAL_W-1], ay_reg} - {by_reg[VAL_W-1], by_reg};
    assign dy_abs = dy[VAL_W] ? (~dy + 1'b1) : dy;
    assign prod_c = mag_reg * dt_reg;

    assign out_load = ctrl.emit && !(out_valid_reg && !out_ready);

    // Read address selection
    always_comb
    begin
        case (ctrl.addr_op)
            ADDR_HOLD: addr_next = addr_reg;
            ADDR_ZERO: addr_next = '0;
            ADDR_LAST: addr_next = num_points - 1'b1;
            ADDR_INC:  addr_next = addr_reg + 1'b1;
            default:   addr_next = addr_reg;
        endcase
    end

    // Breakpoint memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            mem_x[ADDR_W'(in_point_index)] <= in_point_x;
            mem_y[ADDR_W'(in_point_index)] <= in_point_y;
        end
        rdx_reg <= mem_x[addr_reg[ADDR_W-1:0]];
        rdy_reg <= mem_y[addr_reg[ADDR_W-1:0]];
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            addr_reg        <= '0;
            rd_addr_reg     <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                point_count_reg <= cfg_wr_data;
            addr_reg    <= addr_next;
            rd_addr_reg <= addr_reg;
            if (ctrl.flag_sample)
                found_reg <= scan_hit && !scan_end;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Advance working registers
    always_ff @(posedge clk)
    begin
        if (accept && (in_command == CMD_EVAL))
            t_reg <= in_time_value;

        if (ctrl.pair_shift)
        begin
            bx_reg <= ax_reg;
            by_reg <= ay_reg;
            ax_reg <= rdx_reg;
            ay_reg <= rdy_reg;
        end

        case (ctrl.calc_op)
            CALC_DIFF:
            begin
                dx_reg  <= ax_reg - bx_reg;
                dt_reg  <= t_reg - bx_reg;
                mag_reg <= dy_abs[VAL_W-1:0];
                neg_reg <= dy[VAL_W];
            end
            CALC_MUL:   prod_reg  <= prod_c;
            CALC_ROUND: numer_reg <= prod_reg + {{(VAL_W+1){1'b0}}, dx_reg[VAL_W-1:1]};
            default:    ;
        endcase

        case (ctrl.res_op)
            RES_ONE:
            begin
                result_reg <= ONE_Q16;
                status_reg <= ST_EMPTY;
            end
            RES_RD_LOW:
            begin
                result_reg <= rdy_reg;
                status_reg <= ST_LOW;
            end
            RES_RD_HIGH:
            begin
                result_reg <= rdy_reg;
                status_reg <= ST_HIGH;
            end
            RES_Y0_MID:
            begin
                result_reg <= by_reg;
                status_reg <= ST_INTERP;
            end
            RES_QUOT:
            begin
                result_reg <= neg_reg ? (by_reg - quotient) : (by_reg + quotient);
                status_reg <= ST_INTERP;
            end
            default: ;
        endcase

        if (out_load)
        begin
            out_value_reg  <= result_reg;
            out_status_reg <= status_reg;
        end
    end

    pwl_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.calc_op == CALC_DIV_START),
        .dividend (numer_reg),
        .divisor  (dx_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Flags for the sequencer
    always_comb
    begin
        flags.eval_accept = accept && (in_command == CMD_EVAL);
        flags.empty       = (num_points == '0);
        flags.le_first    = ($signed(t_reg) <= $signed(rdx_reg));
        flags.ge_last     = ($signed(t_reg) >= $signed(rdx_reg));
        flags.scan_on     = !(scan_end || scan_hit);
        flags.not_found   = !found_reg;
        flags.zero_width  = (ax_reg == bx_reg);
        flags.div_busy    = div_busy;
        flags.out_full    = out_valid_reg && !out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_curve_value = out_value_reg;
    assign out_eval_status = out_status_reg;

endmodule

// ===== sv/pwl_sequencer.sv =====
// Microprogram ROM, step counter and jump logic.
module pwl_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  pwl_pkg::dp_flags_t  flags,
    output pwl_pkg::dp_ctrl_t   ctrl
);
    import pwl_pkg::*;

    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IDLE_WAIT,
        COND_EMPTY,
        COND_LE_FIRST,
        COND_GE_LAST,
        COND_SCAN_ON,
        COND_NOT_FOUND,
        COND_ZERO_WIDTH,
        COND_DIV_BUSY,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        dp_ctrl_t ctrl;
        cond_t    cond;
        step_t    target;
    } uword_t;

    // Program steps
    localparam step_t S_IDLE      = 4'd0;
    localparam step_t S_EMPTY     = 4'd1;
    localparam step_t S_LOW       = 4'd2;
    localparam step_t S_HIGH      = 4'd3;
    localparam step_t S_PRIME     = 4'd4;
    localparam step_t S_SCAN      = 4'd5;
    localparam step_t S_DECIDE    = 4'd6;
    localparam step_t S_DIFF      = 4'd7;
    localparam step_t S_MUL       = 4'd8;
    localparam step_t S_ROUND     = 4'd9;
    localparam step_t S_DIV_START = 4'd10;
    localparam step_t S_DIV_WAIT  = 4'd11;
    localparam step_t S_EMIT      = 4'd12;
    localparam step_t S_RETURN    = 4'd13;

    function automatic uword_t mk(logic rdy, addr_op_t ao, logic sh, logic fs,
                                  res_op_t ro, calc_op_t co, logic em,
                                  cond_t cd, step_t tg);
        uword_t w;
        w.ctrl.in_ready    = rdy;
        w.ctrl.addr_op     = ao;
        w.ctrl.pair_shift  = sh;
        w.ctrl.flag_sample = fs;
        w.ctrl.res_op      = ro;
        w.ctrl.calc_op     = co;
        w.ctrl.emit        = em;
        w.cond             = cd;
        w.target           = tg;
        return w;
    endfunction

    // Control store: every op runs each cycle, jumps pick the next step
    function automatic uword_t ucode(step_t s);
        uword_t w;
        case (s)
            S_IDLE:      w = mk(1'b1, ADDR_ZERO, 1'b0, 1'b0, RES_HOLD, CALC_NONE, 1'b0,
                                COND_IDLE_WAIT, S_IDLE);
            S_EMPTY:     w = mk(1'b0, ADDR_LAST, 1'b0, 1'b0, RES_ONE, CALC_NONE, 1'b0,
                                COND_EMPTY, S_EMIT);
            S_LOW:       w = mk(1'b0, ADDR_ZERO, 1'b0, 1'b0, RES_RD_LOW, CALC_NONE, 1'b0,
                                COND_LE_FIRST, S_EMIT);
            S_HIGH:      w = mk(1'b0, ADDR_INC, 1'b0, 1'b0, RES_RD_HIGH, CALC_NONE, 1'b0,
                                COND_GE_LAST, S_EMIT);
            S_PRIME:     w = mk(1'b0, ADDR_INC, 1'b1, 1'b0, RES_HOLD, CALC_NONE, 1'b0,
                                COND_NEVER, S_IDLE);
            S_SCAN:      w = mk(1'b0, ADDR_INC, 1'b1, 1'b1, RES_HOLD, CALC_NONE, 1'b0,
                                COND_SCAN_ON, S_SCAN);
            S_DECIDE:    w = mk(1'b0, ADDR_HOLD, 1'b0, 1'b0, RES_HOLD, CALC_NONE, 1'b0,
                                COND_NOT_FOUND, S_EMIT);
            S_DIFF:      w = mk(1'b0, ADDR_HOLD, 1'b0, 1'b0, RES_Y0_MID, CALC_DIFF, 1'b0,
                                COND_ZERO_WIDTH, S_EMIT);
            S_MUL:       w = mk(1'b0, ADDR_HOLD, 1'b0, 1'b0, RES_HOLD, CALC_MUL, 1'b0,
                                COND_NEVER, S_IDLE);
            S_ROUND:     w = mk(1'b0, ADDR_HOLD, 1'b0, 1'b0, RES_HOLD, CALC_ROUND, 1'b0,
                                COND_NEVER, S_IDLE);
            S_DIV_START: w = mk(1'b0, ADDR_HOLD, 1'b0, 1'b0, RES_HOLD, CALC_DIV_START, 1'b0,
                                COND_NEVER, S_IDLE);
            S_DIV_WAIT:  w = mk(1'b0, ADDR_HOLD, 1'b0, 1'b0, RES_QUOT, CALC_NONE, 1'b0,
                                COND_DIV_BUSY, S_DIV_WAIT);
            S_EMIT:      w = mk(1'b0, ADDR_HOLD, 1'b0, 1'b0, RES_HOLD, CALC_NONE, 1'b1,
                                COND_OUT_FULL, S_EMIT);
            S_RETURN:    w = mk(1'b0, ADDR_ZERO, 1'b0, 1'b0, RES_HOLD, CALC_NONE, 1'b0,
                                COND_ALWAYS, S_IDLE);
            default:     w = mk(1'b0, ADDR_ZERO, 1'b0, 1'b0, RES_HOLD, CALC_NONE, 1'b0,
                                COND_ALWAYS, S_IDLE);
        endcase
        return w;
    endfunction

    step_t  pc_reg;
    step_t  pc_next;
    uword_t uw;
    logic   jump;

    assign uw   = ucode(pc_reg);
    assign ctrl = uw.ctrl;

    // Evaluate the jump condition
    always_comb
    begin
        case (uw.cond)
            COND_NEVER:      jump = 1'b0;
            COND_ALWAYS:     jump = 1'b1;
            COND_IDLE_WAIT:  jump = !flags.eval_accept;
            COND_EMPTY:      jump = flags.empty;
            COND_LE_FIRST:   jump = flags.le_first;
            COND_GE_LAST:    jump = flags.ge_last;
            COND_SCAN_ON:    jump = flags.scan_on;
            COND_NOT_FOUND:  jump = flags.not_found;
            COND_ZERO_WIDTH: jump = flags.zero_width;
            COND_DIV_BUSY:   jump = flags.div_busy;
            COND_OUT_FULL:   jump = flags.out_full;
            default:         jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + 1'b1;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= S_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== sv/piecewise_linear_curve_eval.sv =====
// Top level of the piecewise linear curve evaluator.
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+------------------------------------
//  s_axis    | in        | tvalid / tready          | tuser: command; tdata: index, x, y, t
//  m_axis    | out       | tvalid / tready          | tdata: curve_value; tuser: status
//  cfg       | in        | cfg_wr_en (no wait)      | cfg_wr_data: point_count
//
// A load request leaves the block ready.
// An evaluate request is answered directly for clamped or empty results; otherwise the sequencer
// scans the breakpoints (up to 64) and, when interpolating, runs a multiply, a rounding step and
// the bit-serial divider; the linear scan and the divider set the run time of a request.
// Reset clears the step counter, point_count and the output valid flag; the table is not cleared.
// A stalled result waits in the output register; the sequencer holds in its emit step.
module piecewise_linear_curve_eval (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] point_index, [37:6] point_x, [69:38] point_y, [101:70] time_value
    input  logic [pwl_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] command
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] curve_value
    output logic [pwl_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [1:0] eval_status
    output logic [pwl_pkg::STATUS_W-1:0]       m_axis_tuser,
    input  logic                                cfg_wr_en,
    input  logic [pwl_pkg::COUNT_W-1:0]        cfg_wr_data
);
    import pwl_pkg::*;

    dp_ctrl_t  ctrl;
    dp_flags_t flags;

    pwl_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    pwl_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .flags           (flags),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (s_axis_tvalid),
        .in_command      (s_axis_tuser),
        .in_point_index  (s_axis_tdata[5:0]),
        .in_point_x      (s_axis_tdata[37:6]),
        .in_point_y      (s_axis_tdata[69:38]),
        .in_time_value   (s_axis_tdata[101:70]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_curve_value (m_axis_tdata),
        .out_eval_status (m_axis_tuser)
    );

    assign s_axis_tready = ctrl.in_ready;

endmodule

// ===== sv/pwl_checker.sv =====
// Port-level assertions for the curve evaluator, bound to the top level.
module pwl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pwl_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [pwl_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import pwl_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An evaluate request makes the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_EVAL) |=> !s_axis_tready)
        else $error("ready stayed high after an evaluate request");

    // A load request keeps the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD) |=> s_axis_tready)
        else $error("ready dropped after a load request");

    // Empty curve reports 1.0
    a_empty_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> m_axis_tdata == ONE_Q16)
        else $error("empty curve result is not 1.0");

    // A new result only appears while the block is busy
    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready)
        else $error("result appeared while idle");

endmodule

bind piecewise_linear_curve_eval pwl_checker u_pwl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/piecewise_linear_curve_eval_checker.sv =====
// Checker for the curve evaluator: tracks the breakpoint store, predicts and compares results.
`timescale 1ns / 1ps

module piecewise_linear_curve_eval_checker
    import pwl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // [5:0] point_index, [37:6] point_x, [69:38] point_y, [101:70] time_value
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] curve_value
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] eval_status
    input  logic [STATUS_W-1:0]    m_axis_tuser,
    input  logic                   cfg_wr_en,
    input  logic [COUNT_W-1:0]     cfg_wr_data,
    output int                     mismatch_count,
    output int                     pending_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [STATUS_W-1:0] status;
    } curve_result_t;

    bit signed [VAL_W-1:0] knot_x [MAX_POINTS];
    bit signed [VAL_W-1:0] knot_y [MAX_POINTS];
    bit [COUNT_W-1:0]      knot_count;
    curve_result_t         expected_curve_q [$];

    // Evaluate the curve held in the shadow store at time t
    function automatic curve_result_t eval_curve(input logic signed [VAL_W-1:0] t);
        curve_result_t r;
        int            n;
        int            i;
        bit            found;
        longint        x0;
        longint        x1;
        longint        y0;
        longint        y1;
        longint        dy;
        logic [63:0]   dx;
        logic [63:0]   dt;
        logic [63:0]   mag;
        logic [63:0]   prod;
        logic [63:0]   q;
        n = (knot_count > MAX_POINTS) ? MAX_POINTS : int'(knot_count);
        found = 1'b0;
        if (n == 0)
        begin
            r.value  = ONE_Q16;
            r.status = ST_EMPTY;
        end
        else if (t <= knot_x[0])
        begin
            r.value  = knot_y[0];
            r.status = ST_LOW;
        end
        else if (t >= knot_x[n-1])
        begin
            r.value  = knot_y[n-1];
            r.status = ST_HIGH;
        end
        else
        begin
            // fall back to the last point if no interval holds t
            r.value  = knot_y[n-1];
            r.status = ST_HIGH;
            for (i = 0; (i + 1 < n) && !found; i++)
            begin
                x0 = knot_x[i];
                x1 = knot_x[i+1];
                if (t >= x0 && t <= x1)
                begin
                    found    = 1'b1;
                    r.status = ST_INTERP;
                    y0 = knot_y[i];
                    y1 = knot_y[i+1];
                    if (x1 == x0)
                    begin
                        r.value = y0[VAL_W-1:0];
                    end
                    else
                    begin
                        // round the offset magnitude half away from zero, then apply the sign
                        dx   = x1 - x0;
                        dt   = t - x0;
                        dy   = y1 - y0;
                        mag  = (dy < 0) ? -dy : dy;
                        prod = mag * dt;
                        q    = (prod + (dx >> 1)) / dx;
                        if (dy < 0)
                            r.value = y0[VAL_W-1:0] - q[VAL_W-1:0];
                        else
                            r.value = y0[VAL_W-1:0] + q[VAL_W-1:0];
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        curve_result_t want;
        if (!rst_n)
        begin
            knot_count = '0;
            expected_curve_q.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            // compare a delivered result with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_curve_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result value %h status %0d",
                                 $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_curve_q.pop_front();
                    if (m_axis_tdata !== want.value || m_axis_tuser !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: value exp %h got %h, status exp %0d got %0d",
                                     $time, want.value, m_axis_tdata,
                                     want.status, m_axis_tuser);
                    end
                end
            end

            // track the point count register
            if (cfg_wr_en)
                knot_count = cfg_wr_data;

            // apply a load or queue the prediction for an evaluate
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == CMD_LOAD)
                begin
                    knot_x[s_axis_tdata[5:0]] = s_axis_tdata[37:6];
                    knot_y[s_axis_tdata[5:0]] = s_axis_tdata[69:38];
                end
                else
                begin
                    expected_curve_q.push_back(eval_curve(s_axis_tdata[101:70]));
                end
            end

            pending_count = expected_curve_q.size();
        end
    end

endmodule

// ===== test/piecewise_linear_curve_eval_tb.sv =====
// Testbench top for the curve evaluator: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module piecewise_linear_curve_eval_tb;
    import pwl_pkg::*;

    localparam int     ITEM_TARGET  = 1550;
    localparam int     DRAIN_CYCLES = 160;
    localparam int     HOLD_CYCLES  = 600;
    localparam longint WATCHDOG_NS  = 64'd20_000_000;
    localparam longint Q_MAX        = 64'sh7FFF_FFFF;
    localparam longint Q_MIN        = -64'sh8000_0000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  cfg_wr_en;
    logic [COUNT_W-1:0]    cfg_wr_data;
    int                    mismatch_count;
    int                    pending_count;

    // stimulus-side copy of the abscissas, used only to aim time values
    logic signed [VAL_W-1:0] aim_x [MAX_POINTS];
    int                      items_sent = 0;
    int                      send_calm  = 0;
    int                      recv_calm  = 0;
    bit                      hold_results = 1'b0;

    piecewise_linear_curve_eval dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    piecewise_linear_curve_eval_checker curve_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Draw an idle count, with occasional stretches of back-to-back traffic
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [VAL_W-1:0] sat32(input longint v);
        if (v > Q_MAX)
            return Q_MAX[VAL_W-1:0];
        if (v < Q_MIN)
            return Q_MIN[VAL_W-1:0];
        return v[VAL_W-1:0];
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input logic cmd, input logic [INDEX_W-1:0] idx,
                                input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] py,
                                input logic [VAL_W-1:0] tv);
        int gap;
        gap = draw_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(S_TDATA_W-3*VAL_W-INDEX_W){1'b0}}, tv, py, px, idx};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic load_point(input int idx, input logic [VAL_W-1:0] px,
                              input logic [VAL_W-1:0] py);
        aim_x[idx] = px;
        send_request(CMD_LOAD, idx[INDEX_W-1:0], px, py, $urandom);
    endtask

    task automatic eval_at(input logic [VAL_W-1:0] tv);
        send_request(CMD_EVAL, $urandom_range(0, MAX_POINTS - 1), $urandom, $urandom, tv);
    endtask

    // Stop offering, wait for every result, then let the sequencer settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_point_count(input int count);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count[COUNT_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_results)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
            stall = draw_gap(recv_calm);
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Request side: directed cases, then random curve phases
    initial
    begin
        int     phase;
        int     count;
        int     n_points;
        int     n_evals;
        int     step_max;
        int     k;
        int     pick;
        longint xs;
        longint x_lo;
        longint x_hi;
        longint span;
        logic [VAL_W-1:0] py;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        rst_n         = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // empty curve after reset
        eval_at(32'h0000_0000);
        eval_at(32'h7FFF_FFFF);

        // extreme abscissas and ordinates, with a repeated abscissa
        load_point(0, 32'h8000_0000, 32'h7FFF_FFFF);
        load_point(1, 32'h0000_0000, 32'h8000_0000);
        load_point(2, 32'h0000_0000, ONE_Q16);
        load_point(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // one-point curve: low at or below the point, high above it
        set_point_count(1);
        eval_at(32'h8000_0000);
        eval_at(32'h8000_0001);

        // clamp at both ends, interpolate across the widest intervals
        set_point_count(4);
        eval_at(32'h8000_0000);
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h0000_0000);
        eval_at(32'h0000_0001);
        eval_at(32'hFFFF_FFFF);
        eval_at(32'h4000_0000);
        eval_at(32'h7FFF_FFFE);

        // half-way ties on rising and falling segments
        set_point_count(3);
        load_point(0, 32'd0, 32'd0);
        load_point(1, 32'd2, 32'd1);
        load_point(2, 32'd4, 32'd0);
        eval_at(32'd1);
        eval_at(32'd3);
        eval_at(32'd2);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            // pick the point count: counts above the table size first, then a full table
            if (phase == 0)
                count = 127;
            else if (phase == 1)
                count = MAX_POINTS;
            else if (phase == 2)
                count = 16;
            else
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    count = 0;
                else if (pick == 1)
                    count = 1;
                else if (pick == 2)
                    count = MAX_POINTS;
                else if (pick == 3)
                    count = $urandom_range(MAX_POINTS + 1, 127);
                else
                    count = $urandom_range(2, 16);
            end
            set_point_count(count);
            n_points = (count > MAX_POINTS) ? MAX_POINTS : count;

            // load a nondecreasing curve with random ordinates
            pick = $urandom_range(0, 3);
            step_max = (pick == 0) ? 4 : (pick == 1) ? 32'h0000_8000 :
                       (pick == 2) ? 32'h0010_0000 : 32'h0200_0000;
            xs = -(longint'(step_max) * n_points) / 2;
            for (k = 0; k < n_points; k++)
            begin
                if ($urandom_range(0, 7) != 0)
                    xs = xs + $urandom_range(0, step_max);
                if ($urandom_range(0, 1) == 0)
                    py = $urandom;
                else
                    py = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                load_point(k, sat32(xs), py);
            end

            // evaluate, mostly inside the curve's range, with occasional random point loads
            n_evals = $urandom_range(30, 70);
            if (phase == 2)
                hold_results = 1'b1;
            repeat (n_evals)
            begin
                pick = $urandom_range(0, 19);
                if (n_points > 0)
                begin
                    x_lo = aim_x[0];
                    x_hi = aim_x[n_points - 1];
                end
                if (pick == 0)
                    load_point($urandom_range(0, MAX_POINTS - 1), $urandom, $urandom);
                else if (pick == 1 || n_points == 0)
                    eval_at($urandom);
                else if (pick == 2)
                    eval_at(sat32(x_lo - $urandom_range(0, 1000)));
                else if (pick == 3)
                    eval_at(sat32(x_hi + $urandom_range(0, 1000)));
                else if (pick <= 5)
                    eval_at(aim_x[$urandom_range(0, n_points - 1)]);
                else if (x_hi > x_lo)
                begin
                    span = x_hi - x_lo;
                    eval_at(sat32(x_lo + longint'({$urandom, $urandom} % (span + 1))));
                end
                else
                    eval_at($urandom);
            end
            phase++;
        end

        drain();
        if (mismatch_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Bound the run time
    initial
    begin
        #(WATCHDOG_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
